// ===== src/rpcdd_pkg.sv =====
`timescale 1ns / 1ps

package rpcdd_pkg;

   // Field widths
   localparam int CH_W     = 3;
   localparam int TIME_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int DUTY_W   = 15;
   localparam int PROD_W   = TIME_W + FRAC_W;

   // Divide datapath: margin * 25600 fits in 47 bits, quotient needs 15 bits
   localparam int NUM_W     = 47;
   localparam int QUOT_BITS = 15;

   localparam int CHANNELS_DEFAULT = 8;

   // 100 percent in Q7.8
   localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd25600;

   localparam logic [FRAC_W-1:0] MIN_FRACTION_RESET  = 16'd3277;
   localparam logic [FRAC_W-1:0] SPAN_FRACTION_RESET = 16'd3277;

   // CSR map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRACTION  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_FRACTION = 1'b1;

endpackage

// ===== src/rpcdd_radix4_mul.sv =====
`timescale 1ns / 1ps

// Serial multiplier, two multiplier bits per cycle, MSB digit first.
module rpcdd_radix4_mul #(
   parameter int A_W = rpcdd_pkg::TIME_W,
   parameter int B_W = rpcdd_pkg::FRAC_W,
   localparam int P_W   = A_W + B_W,
   localparam int STEPS = B_W / 2,
   localparam int CNT_W = $clog2(STEPS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           busy,
   output logic [P_W-1:0] product
);

   logic [A_W-1:0]   a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [A_W+1:0]   partial;

   // a times the current radix-4 digit
   always_comb begin
      case (b_ff[B_W-1:B_W-2])
         2'd0:    partial = '0;
         2'd1:    partial = {2'b00, a_ff};
         2'd2:    partial = {1'b0, a_ff, 1'b0};
         default: partial = {2'b00, a_ff} + {1'b0, a_ff, 1'b0};
      endcase
   end

   // Next state
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[P_W-3:0], 2'b00} + P_W'(partial);
         b_in   = {b_ff[B_W-3:0], 2'b00};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

// ===== src/rpcdd_chan_store.sv =====
`timescale 1ns / 1ps

// Per-channel rise and fall timestamps, one write per cycle.
module rpcdd_chan_store #(
   parameter int CHANNELS = rpcdd_pkg::CHANNELS_DEFAULT,
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic                        wr_rise,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [rpcdd_pkg::TIME_W-1:0] wr_data,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [rpcdd_pkg::TIME_W-1:0] rd_rise,
   output logic [rpcdd_pkg::TIME_W-1:0] rd_fall
);

   logic [rpcdd_pkg::TIME_W-1:0] rise_ff [CHANNELS];
   logic [rpcdd_pkg::TIME_W-1:0] fall_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            rise_ff[i] <= '0;
            fall_ff[i] <= '0;
         end
      end else if (wr_en) begin
         if (wr_rise) begin
            rise_ff[wr_idx] <= wr_data;
         end else begin
            fall_ff[wr_idx] <= wr_data;
         end
      end
   end

   assign rd_rise = rise_ff[rd_idx];
   assign rd_fall = fall_ff[rd_idx];

endmodule

// ===== src/rc_pwm_capture_duty_decoder.sv =====
`timescale 1ns / 1ps

// RC PWM capture duty decoder.
// req channel: one capture beat (channel, capture_time, pin_level) per accept,
//   accepted when req_valid is high and req_stall is low.
// A falling-edge beat stores the fall time and yields nothing.
// A rising-edge beat yields one rsp beat (out_channel, duty_percent in Q7.8)
//   and records the rise time. Channels at or above CHANNELS are dropped.
// States of a rising beat: load, multiply, margin, check, divide, clamp,
//   finish; a width under the minimum or a zero span skips from margin to
//   finish, a saturating quotient from check to finish. Two radix-4 serial
//   multipliers (8 steps) give the span and minimum products, a restoring
//   divider the quotient, one bit per cycle (15 steps). One rising beat is
//   in work at a time; the next beat is taken the cycle after rsp is loaded.
// rsp channel: the result sits in an output register; if rsp_stall holds it,
//   the block may still accept the next beat and work on it; that result waits
//   in the finish state, with req stalled, until the output register is free.
// csr channel: csr_ready is always high; index 0 min_fraction, index 1
//   span_fraction, Q0.16. Write only while idle.
// Reset (synchronous): all timestamps go to zero, fractions to 3277, no
//   result pending.
module rc_pwm_capture_duty_decoder #(
   parameter int CHANNELS = rpcdd_pkg::CHANNELS_DEFAULT,
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   // capture beats
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rpcdd_pkg::CH_W-1:0]        req_channel,
   input  logic [rpcdd_pkg::TIME_W-1:0]      req_capture_time,
   input  logic                              req_pin_level,
   // duty beats
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rpcdd_pkg::CH_W-1:0]        rsp_out_channel,
   output logic [rpcdd_pkg::DUTY_W-1:0]      rsp_duty_percent,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rpcdd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpcdd_pkg::FRAC_W-1:0]      csr_wdata
);

   localparam int TW = rpcdd_pkg::TIME_W;
   localparam int NW = rpcdd_pkg::NUM_W;
   localparam int QB = rpcdd_pkg::QUOT_BITS;
   localparam int DW = rpcdd_pkg::DUTY_W;
   localparam int PW = rpcdd_pkg::PROD_W;
   localparam int FW = rpcdd_pkg::FRAC_W;
   localparam int QCNT_W = $clog2(QB + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_MARGIN,
      ST_CHECK,
      ST_DIV,
      ST_CLAMP,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [rpcdd_pkg::CH_W-1:0]   ch_ff, ch_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [TW-1:0]                time_ff, time_in;
   logic [TW-1:0]                width_ff, width_in;
   logic [NW-1:0]                num_ff, num_in;
   logic [TW-1:0]                rem_ff, rem_in;
   logic [QB-1:0]                quot_ff, quot_in;
   logic [QCNT_W-1:0]            cnt_ff, cnt_in;
   logic [DW-1:0]                duty_ff, duty_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rpcdd_pkg::CH_W-1:0]   rsp_ch_ff, rsp_ch_in;
   logic [DW-1:0]                rsp_duty_ff, rsp_duty_in;
   logic [FW-1:0]                min_frac_ff, min_frac_in;
   logic [FW-1:0]                span_frac_ff, span_frac_in;

   logic                         req_accept;
   logic [7:0]                   chan_ext;
   logic                         chan_ok;
   logic                         wr_en, wr_rise;
   logic [IDX_W-1:0]             wr_idx;
   logic [TW-1:0]                wr_data;
   logic [TW-1:0]                rd_rise, rd_fall;
   logic [TW-1:0]                period;
   logic                         mul_start;
   logic                         lo_busy, span_busy;
   logic [PW-1:0]                lo_prod, span_prod;
   logic [TW-1:0]                lo, span;
   logic [TW-1:0]                margin;
   logic [NW-1:0]                margin_ext;
   logic [TW:0]                  trial;
   logic                         trial_ge;

   // Channel range check and store index
   assign chan_ext   = {5'b00000, req_channel};
   assign chan_ok    = chan_ext < 8'(CHANNELS);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   rpcdd_chan_store #(
      .CHANNELS(CHANNELS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_rise (wr_rise),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (idx_ff),
      .rd_rise (rd_rise),
      .rd_fall (rd_fall)
   );

   // Period and the two fractions of it
   assign period    = time_ff - rd_rise;
   assign mul_start = (state_ff == ST_LOAD);

   rpcdd_radix4_mul #(
      .A_W(TW),
      .B_W(FW)
   ) u_mul_lo (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (period),
      .b       (min_frac_ff),
      .busy    (lo_busy),
      .product (lo_prod)
   );

   rpcdd_radix4_mul #(
      .A_W(TW),
      .B_W(FW)
   ) u_mul_span (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (period),
      .b       (span_frac_ff),
      .busy    (span_busy),
      .product (span_prod)
   );

   assign lo   = lo_prod[PW-1:FW];
   assign span = span_prod[PW-1:FW];

   // margin * 25600 = (m << 14) + (m << 13) + (m << 10)
   assign margin     = width_ff - lo;
   assign margin_ext = NW'(margin);

   // Restoring divide step
   assign trial    = {rem_ff, num_ff[QB-1]};
   assign trial_ge = trial >= {1'b0, span};

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      width_in     = width_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ch_in    = rsp_ch_ff;
      rsp_duty_in  = rsp_duty_ff;
      min_frac_in  = min_frac_ff;
      span_frac_in = span_frac_ff;
      wr_en        = 1'b0;
      wr_rise      = 1'b0;
      wr_idx       = idx_ff;
      wr_data      = time_ff;

      // output beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpcdd_pkg::CSR_MIN_FRACTION:  min_frac_in  = csr_wdata;
            rpcdd_pkg::CSR_SPAN_FRACTION: span_frac_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && chan_ok) begin
               if (req_pin_level) begin
                  ch_in    = req_channel;
                  idx_in   = chan_ext[IDX_W-1:0];
                  time_in  = req_capture_time;
                  state_in = ST_LOAD;
               end else begin
                  wr_en   = 1'b1;
                  wr_rise = 1'b0;
                  wr_idx  = chan_ext[IDX_W-1:0];
                  wr_data = req_capture_time;
               end
            end
         end
         ST_LOAD: begin
            // read old stamps, then the new rise time replaces the old one
            width_in = rd_fall - rd_rise;
            wr_en    = 1'b1;
            wr_rise  = 1'b1;
            wr_idx   = idx_ff;
            wr_data  = time_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (!lo_busy) begin
               state_in = ST_MARGIN;
            end
         end
         ST_MARGIN: begin
            if (width_ff <= lo) begin
               duty_in  = '0;
               state_in = ST_FINISH;
            end else if (span == '0) begin
               duty_in  = rpcdd_pkg::FULL_DUTY;
               state_in = ST_FINISH;
            end else begin
               num_in   = (margin_ext << 14) + (margin_ext << 13) + (margin_ext << 10);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // quotient of 2^15 or more saturates
            if (num_ff >= {span, {QB{1'b0}}}) begin
               duty_in  = rpcdd_pkg::FULL_DUTY;
               state_in = ST_FINISH;
            end else begin
               rem_in   = num_ff[NW-1:QB];
               quot_in  = '0;
               cnt_in   = QCNT_W'(QB);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial_ge) begin
               rem_in = TW'(trial - {1'b0, span});
            end else begin
               rem_in = trial[TW-1:0];
            end
            quot_in = {quot_ff[QB-2:0], trial_ge};
            num_in  = {num_ff[NW-2:0], 1'b0};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == QCNT_W'(1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            duty_in  = (quot_ff > rpcdd_pkg::FULL_DUTY) ? rpcdd_pkg::FULL_DUTY : quot_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = ch_ff;
               rsp_duty_in  = duty_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      idx_ff      <= idx_in;
      time_ff     <= time_in;
      width_ff    <= width_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      duty_ff     <= duty_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_duty_ff <= rsp_duty_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_frac_ff  <= rpcdd_pkg::MIN_FRACTION_RESET;
         span_frac_ff <= rpcdd_pkg::SPAN_FRACTION_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         min_frac_ff  <= min_frac_in;
         span_frac_ff <= span_frac_in;
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_ch_ff;
   assign rsp_duty_percent = rsp_duty_ff;

   // Checks
   a_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= rpcdd_pkg::FULL_DUTY)
      else $error("duty above full scale");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < span)
      else $error("divider remainder not below span");

   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARGIN |-> !lo_busy && !span_busy)
      else $error("multipliers still busy at margin step");

   a_load_then_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> lo_busy && span_busy)
      else $error("multipliers did not start");

endmodule

// ===== tb/sv/tb_rc_pwm_capture_duty_decoder.sv =====
`timescale 1ns / 1ps

module tb_rc_pwm_capture_duty_decoder;

   localparam int CH_W             = rpcdd_pkg::CH_W;
   localparam int TIME_W           = rpcdd_pkg::TIME_W;
   localparam int FRAC_W           = rpcdd_pkg::FRAC_W;
   localparam int DUTY_W           = rpcdd_pkg::DUTY_W;
   localparam int CSR_IDX_W        = rpcdd_pkg::CSR_IDX_W;
   localparam int CHANNELS_DEFAULT = rpcdd_pkg::CHANNELS_DEFAULT;

   localparam int CLK_HALF_NS   = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_NS      = 4_000_000;

   // pin level after the captured edge
   localparam logic EDGE_FALL = 1'b0;
   localparam logic EDGE_RISE = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [DUTY_W-1:0] duty;
   } duty_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CH_W-1:0]      req_channel = '0;
   logic [TIME_W-1:0]    req_capture_time = '0;
   logic                 req_pin_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CH_W-1:0]      rsp_out_channel;
   logic [DUTY_W-1:0]    rsp_duty_percent;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [FRAC_W-1:0]    csr_wdata = '0;

   // expected duty beats and the timestamp state that produces them
   duty_beat_type     pending_duty_q[$];
   logic [TIME_W-1:0] rise_stamp [CHANNELS_DEFAULT] = '{default: '0};
   logic [TIME_W-1:0] fall_stamp [CHANNELS_DEFAULT] = '{default: '0};
   logic [FRAC_W-1:0] min_frac  = rpcdd_pkg::MIN_FRACTION_RESET;
   logic [FRAC_W-1:0] span_frac = rpcdd_pkg::SPAN_FRACTION_RESET;

   logic steady = 1'b0;   // no gaps on either side while set
   int   capture_count  = 0;
   int   duty_count     = 0;
   int   mismatch_count = 0;
   int   setting_count  = 0;

   rc_pwm_capture_duty_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_capture_time (req_capture_time),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_duty_percent (rsp_duty_percent),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // duty of one period: width above the minimum, scaled over the span, clamped
   function automatic logic [DUTY_W-1:0] predict_duty(input logic [TIME_W-1:0] stamp,
                                                      input logic [TIME_W-1:0] rise,
                                                      input logic [TIME_W-1:0] fall);
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] width;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] span;
      logic [63:0]       q;
      period = stamp - rise;
      width  = fall - rise;
      lo     = TIME_W'((64'(period) * min_frac) >> FRAC_W);
      span   = TIME_W'((64'(period) * span_frac) >> FRAC_W);
      if (width <= lo)
         return '0;
      if (span == '0)
         return rpcdd_pkg::FULL_DUTY;
      q = (64'(width - lo) * 64'(rpcdd_pkg::FULL_DUTY)) / 64'(span);
      if (q > 64'(rpcdd_pkg::FULL_DUTY))
         return rpcdd_pkg::FULL_DUTY;
      return DUTY_W'(q);
   endfunction

   // result side: random stall, check each accepted duty beat
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 18);
   end

   always @(posedge clock) begin
      duty_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         duty_count++;
         if (pending_duty_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: duty beat with none expected: ch %0d duty %0d",
                        rsp_out_channel, rsp_duty_percent);
         end else begin
            want = pending_duty_q.pop_front();
            if (rsp_out_channel !== want.channel || rsp_duty_percent !== want.duty) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: expected ch %0d duty %0d, got ch %0d duty %0d",
                           want.channel, want.duty, rsp_out_channel, rsp_duty_percent);
            end
         end
      end
   end

   // one capture beat; predicts on accept
   task automatic send_capture(input logic [CH_W-1:0] ch, input logic [TIME_W-1:0] stamp,
                               input logic level);
      if (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(32, 1)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_channel      <= ch;
      req_capture_time <= stamp;
      req_pin_level    <= level;
      do @(posedge clock); while (!(req_valid && !req_stall));
      capture_count++;
      if (level == EDGE_FALL) begin
         fall_stamp[ch] = stamp;
      end else begin
         pending_duty_q.push_back(duty_beat_type'{channel: ch,
            duty: predict_duty(stamp, rise_stamp[ch], fall_stamp[ch])});
         rise_stamp[ch] = stamp;
      end
   endtask

   // hold the sender until every expected duty beat is out, then let work finish
   task automatic wait_for_duty_drain();
      req_valid <= 1'b0;
      while (pending_duty_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both fractions, written while idle
   task automatic set_fractions(input logic [FRAC_W-1:0] min_value,
                                input logic [FRAC_W-1:0] span_value);
      wait_for_duty_drain();
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? rpcdd_pkg::CSR_MIN_FRACTION : rpcdd_pkg::CSR_SPAN_FRACTION;
         csr_wdata <= (i == 0) ? min_value : span_value;
         do @(posedge clock); while (!(csr_valid && csr_ready));
         if (i == 0)
            min_frac = min_value;
         else
            span_frac = span_value;
      end
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // mostly clean fall/rise frames per channel, plus lone rises and noise
   task automatic run_random_frames(input int n_items);
      int                sent;
      int unsigned       pick;
      logic [CH_W-1:0]   ch;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] width;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] span;
      sent = 0;
      while (sent < n_items) begin
         ch   = CH_W'($urandom_range(CHANNELS_DEFAULT - 1));
         pick = $urandom_range(99);
         if (pick < 80) begin
            case ($urandom_range(19))
               0:       period = $urandom;
               1, 2:    period = $urandom_range(2000, 1);
               default: period = $urandom_range(60000, 2000);
            endcase
            lo   = TIME_W'((64'(period) * min_frac) >> FRAC_W);
            span = TIME_W'((64'(period) * span_frac) >> FRAC_W);
            case ($urandom_range(9))
               0:       width = $urandom_range(lo, 0);
               1:       width = lo + span + $urandom_range(period / 4, 0);
               default: width = TIME_W'(lo + ({$urandom, $urandom} % (64'(span) + 1)));
            endcase
            send_capture(ch, rise_stamp[ch] + width, EDGE_FALL);
            send_capture(ch, rise_stamp[ch] + period, EDGE_RISE);
            sent += 2;
         end else if (pick < 90) begin
            // rise with a stale fall time
            send_capture(ch, rise_stamp[ch] + $urandom_range(60000, 1), EDGE_RISE);
            sent++;
         end else begin
            send_capture(ch, $urandom, 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   // zero period and zero width straight out of reset, top channel, top timestamp
   task automatic test_power_on_state();
      send_capture(3'd0, 32'h0000_0000, EDGE_RISE);
      send_capture(3'd7, 32'hFFFF_FFFF, EDGE_RISE);
   endtask

   // 20000-tick frame: mid scale and exactly at the minimum
   task automatic test_nominal_duty();
      send_capture(3'd1, 32'd1500, EDGE_FALL);
      send_capture(3'd1, 32'd20000, EDGE_RISE);
      send_capture(3'd1, 32'd21000, EDGE_FALL);
      send_capture(3'd1, 32'd40000, EDGE_RISE);
   endtask

   // width under the minimum gives zero
   task automatic test_below_minimum();
      send_capture(3'd3, 32'd500, EDGE_FALL);
      send_capture(3'd3, 32'd20000, EDGE_RISE);
   endtask

   // width beyond minimum plus span clamps at full scale
   task automatic test_saturation();
      send_capture(3'd4, 32'd5000, EDGE_RISE);
      send_capture(3'd4, 32'd20000, EDGE_FALL);
      send_capture(3'd4, 32'd25000, EDGE_RISE);
   endtask

   // frame across the timer wrap, then a rise whose fall time is stale
   task automatic test_timer_wrap();
      send_capture(3'd2, 32'hFFFF_C000, EDGE_RISE);
      send_capture(3'd2, 32'hFFFF_C000 + 32'd1500, EDGE_FALL);
      send_capture(3'd2, 32'hFFFF_C000 + 32'd20000, EDGE_RISE);
      send_capture(3'd2, 32'hFFFF_C000 + 32'd40000, EDGE_RISE);
   endtask

   // zero span: full scale with a positive margin, zero without
   task automatic test_zero_span();
      set_fractions(rpcdd_pkg::MIN_FRACTION_RESET, 16'd0);
      send_capture(3'd5, 32'd100, EDGE_RISE);
      send_capture(3'd5, 32'd3100, EDGE_FALL);
      send_capture(3'd5, 32'd20100, EDGE_RISE);
      send_capture(3'd5, 32'd20600, EDGE_FALL);
      send_capture(3'd5, 32'd40100, EDGE_RISE);
      set_fractions(16'd0, 16'd0);
      send_capture(3'd5, 32'd40100, EDGE_FALL);
      send_capture(3'd5, 32'd60100, EDGE_RISE);
   endtask

   // fractions at both ends of their range
   task automatic test_fraction_extremes();
      set_fractions(16'd0, 16'hFFFF);
      send_capture(3'd6, 32'd10000, EDGE_FALL);
      send_capture(3'd6, 32'd40000, EDGE_RISE);
      set_fractions(16'hFFFF, 16'hFFFF);
      send_capture(3'd6, 32'd45000, EDGE_FALL);
      send_capture(3'd6, 32'd80000, EDGE_RISE);
   endtask

   // random frames over several fraction settings, with a full drain mid-phase
   task automatic test_random_traffic();
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       set_fractions(rpcdd_pkg::MIN_FRACTION_RESET,
                                   rpcdd_pkg::SPAN_FRACTION_RESET);
            1:       set_fractions(16'd6554, 16'd3277);
            2:       set_fractions(16'd0, 16'hFFFF);
            3:       set_fractions(16'hFFFF, 16'hFFFF);
            4:       set_fractions(16'd0, 16'd0);
            default: set_fractions(FRAC_W'($urandom), FRAC_W'($urandom));
         endcase
         steady <= (p == 1);
         run_random_frames(48);
         wait_for_duty_drain();
         run_random_frames(48);
      end
      steady <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_power_on_state();
      test_nominal_duty();
      test_below_minimum();
      test_saturation();
      test_timer_wrap();
      test_zero_span();
      test_fraction_extremes();
      test_random_traffic();
      wait_for_duty_drain();
      $display("Sent %0d capture beats on all channels; checked %0d duty beats", capture_count,
               duty_count);
      $display("across %0d fraction settings, including zero and full-scale fractions",
               setting_count);
      if (mismatch_count == 0 && pending_duty_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Mismatches: %0d, duty beats still expected: %0d", mismatch_count,
                  pending_duty_q.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
